/* hdl/u2u_pkg.sv */
// Shared types, constants and byte classification for the UTF-8 to UTF-16 transcoder.
package u2u_pkg;

    // Code unit constants
    localparam logic [15:0] UNIT_REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] UNIT_HIGH_BASE   = 16'hD800;
    localparam logic [15:0] UNIT_LOW_BASE    = 16'hDC00;
    localparam logic [9:0]  UNIT_LOW_MASK    = 10'h3FF;
    localparam logic [19:0] POINT_PLANE_BASE = 20'h10000;

    // Lead bytes with range rules on the second byte
    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_ED = 8'hED;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;
    localparam logic [7:0] TRAIL_A0 = 8'hA0;
    localparam logic [7:0] TRAIL_9F = 8'h9F;
    localparam logic [7:0] TRAIL_90 = 8'h90;
    localparam logic [7:0] TRAIL_8F = 8'h8F;

    // Sequence lengths
    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    // Depth of the queue between front and back
    localparam int JOB_QUEUE_DEPTH = 2;

    // Class of a byte taken with no sequence open
    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } t_lead;

    // Units produced by one input byte
    typedef struct packed {
        logic [1:0]  cnt;
        logic [15:0] unit_a;
        logic [15:0] unit_b;
        logic        last;
    } t_job;

    function automatic t_lead classify_lead(input logic [7:0] b);
        t_lead k;
        case (b) inside
            [8'h00:8'h7F]: k = LEAD_ASCII;
            [8'hC2:8'hDF]: k = LEAD_TWO;
            [8'hE0:8'hEF]: k = LEAD_THREE;
            [8'hF0:8'hF4]: k = LEAD_FOUR;
            default:       k = LEAD_BAD;
        endcase
        return k;
    endfunction

endpackage

/* hdl/u2u_front.sv */
// Front end: decodes UTF-8 bytes and turns each into a job of up to two code units.
module u2u_front import u2u_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_text_byte,
    input  logic       i_text_last,
    input  logic       i_queue_full,
    output logic       o_job_push,
    output t_job       o_job
);

    logic [2:0]  r_exp_len, n_exp_len;
    logic [2:0]  r_seen, n_seen;
    logic [7:0]  r_lead, n_lead;
    logic [20:0] r_acc, n_acc;
    logic        r_viol, n_viol;

    logic        accept;
    t_job        job;

    assign accept = i_push && !i_queue_full;

    // Decode one byte against the open sequence
    always_comb begin
        logic        fresh;
        logic [2:0]  seen_p;
        logic [20:0] acc_p;
        logic        viol_p;
        logic [20:0] point;
        logic [19:0] offs;
        logic [15:0] unit_f;
        logic        emit_f;
        t_lead       kind;

        n_exp_len = r_exp_len;
        n_seen    = r_seen;
        n_lead    = r_lead;
        n_acc     = r_acc;
        n_viol    = r_viol;
        job       = '0;
        job.last  = i_text_last;
        fresh     = 1'b0;
        seen_p    = r_seen + 3'd1;
        acc_p     = {r_acc[14:0], i_text_byte[5:0]};
        viol_p    = r_viol;
        point     = '0;
        offs      = '0;
        unit_f    = UNIT_REPLACEMENT;
        emit_f    = 1'b0;
        kind      = classify_lead(i_text_byte);

        if (r_exp_len != SEQ_NONE) begin
            if (i_text_byte[7:6] == 2'b10) begin
                // Continuation: gather bits and check the second-byte range
                if (seen_p == 3'd2) begin
                    if ((r_lead == LEAD_E0 && i_text_byte < TRAIL_A0) ||
                        (r_lead == LEAD_ED && i_text_byte > TRAIL_9F) ||
                        (r_lead == LEAD_F0 && i_text_byte < TRAIL_90) ||
                        (r_lead == LEAD_F4 && i_text_byte > TRAIL_8F)) begin
                        viol_p = 1'b1;
                    end
                end
                if (seen_p >= r_exp_len) begin
                    point = viol_p ? {5'd0, UNIT_REPLACEMENT} : acc_p;
                    offs  = point[19:0] - POINT_PLANE_BASE;
                    if (point > 21'h00FFFF) begin
                        job.unit_a = UNIT_HIGH_BASE + {6'd0, offs[19:10]};
                        job.unit_b = UNIT_LOW_BASE + {6'd0, offs[9:0] & UNIT_LOW_MASK};
                        job.cnt    = 2'd2;
                    end else begin
                        job.unit_a = point[15:0];
                        job.cnt    = 2'd1;
                    end
                    n_exp_len = SEQ_NONE;
                    n_seen    = '0;
                    n_lead    = '0;
                    n_acc     = '0;
                    n_viol    = 1'b0;
                end else begin
                    n_seen = seen_p;
                    n_acc  = acc_p;
                    n_viol = viol_p;
                end
            end else begin
                // Cut sequence: replace it and restart on this byte
                job.unit_a = UNIT_REPLACEMENT;
                job.cnt    = 2'd1;
                n_exp_len  = SEQ_NONE;
                n_seen     = '0;
                n_lead     = '0;
                n_acc      = '0;
                n_viol     = 1'b0;
                fresh      = 1'b1;
            end
        end else begin
            fresh = 1'b1;
        end

        // Start afresh: emit directly or open a sequence
        if (fresh) begin
            case (kind)
                LEAD_ASCII: begin
                    emit_f = 1'b1;
                    unit_f = {8'd0, i_text_byte};
                end
                LEAD_TWO: begin
                    n_exp_len = SEQ_TWO;
                    n_acc     = {16'd0, i_text_byte[4:0]};
                end
                LEAD_THREE: begin
                    n_exp_len = SEQ_THREE;
                    n_acc     = {17'd0, i_text_byte[3:0]};
                end
                LEAD_FOUR: begin
                    n_exp_len = SEQ_FOUR;
                    n_acc     = {18'd0, i_text_byte[2:0]};
                end
                default: begin
                    emit_f = 1'b1;
                    unit_f = UNIT_REPLACEMENT;
                end
            endcase
            if (kind == LEAD_TWO || kind == LEAD_THREE || kind == LEAD_FOUR) begin
                n_seen = 3'd1;
                n_lead = i_text_byte;
                n_viol = 1'b0;
            end
        end

        // End of text: replace an open sequence and close everything
        if (i_text_last && n_exp_len != SEQ_NONE) begin
            emit_f = 1'b1;
            unit_f = UNIT_REPLACEMENT;
        end
        if (emit_f) begin
            if (job.cnt == 2'd0) begin
                job.unit_a = unit_f;
            end else begin
                job.unit_b = unit_f;
            end
            job.cnt = job.cnt + 2'd1;
        end
        if (i_text_last) begin
            n_exp_len = SEQ_NONE;
            n_seen    = '0;
            n_lead    = '0;
            n_acc     = '0;
            n_viol    = 1'b0;
        end
    end

    // Hold decoder state; advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= SEQ_NONE;
            r_seen    <= '0;
            r_lead    <= '0;
            r_acc     <= '0;
            r_viol    <= 1'b0;
        end else if (accept) begin
            r_exp_len <= n_exp_len;
            r_seen    <= n_seen;
            r_lead    <= n_lead;
            r_acc     <= n_acc;
            r_viol    <= n_viol;
        end
    end

    // Drop jobs that carry no units
    assign o_job_push = accept && (job.cnt != 2'd0);
    assign o_job      = job;

endmodule

/* hdl/u2u_queue.sv */
// Small register queue of jobs between the front and back ends.
module u2u_queue import u2u_pkg::*; #(
    parameter int DEPTH = JOB_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hdl/u2u_back.sv */
// Back end: splits each job into code units and holds them in the output register.
module u2u_back import u2u_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_empty,
    input  t_job        i_job,
    output logic        o_job_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [15:0] o_code_unit,
    output logic        o_run_last,
    output logic        o_text_end
);

    logic        r_out_valid;
    logic        r_phase;
    logic [15:0] r_code_unit;
    logic        r_run_last;
    logic        r_text_end;
    logic        load;
    logic        final_unit;

    // Reload the output register when empty or on a transfer
    assign load       = !r_out_valid || i_pop;
    assign final_unit = (i_job.cnt == 2'd1) || r_phase;
    assign o_job_pop  = load && !i_job_empty && final_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else if (load) begin
            r_out_valid <= !i_job_empty;
            if (!i_job_empty) begin
                r_phase <= !final_unit;
            end
        end
    end

    // Select the next unit of the head job
    always_ff @(posedge i_clk) begin
        if (load && !i_job_empty) begin
            r_code_unit <= r_phase ? i_job.unit_b : i_job.unit_a;
            r_run_last  <= final_unit;
            r_text_end  <= final_unit && i_job.last;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_code_unit = r_code_unit;
    assign o_run_last  = r_run_last;
    assign o_text_end  = r_text_end;

endmodule

/* hdl/utf8_to_utf16_transcoder_core.sv */
// Top level of the UTF-8 to UTF-16 transcoder: front decoder, job queue, unit serializer.
//
//  Channel   Direction  Handshake          Payload
//  input     in         push / full        i_text_byte, i_text_last
//  result    out        empty / pop        o_code_unit, o_run_last, o_text_end
//
// One byte is taken per cycle while full is low; its job passes a queue slot, then the output
// register. A byte that yields two code units holds the serializer until both go out, so the
// output side sets the rate: one code unit per cycle while popped, buffered by the job queue.
// Reset is synchronous and clears the decoder state, queue and output register.
// Either side may stall at any time without loss.
module utf8_to_utf16_transcoder_core import u2u_pkg::*; #(
    parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_text_last,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_code_unit,
    output logic        o_run_last,
    output logic        o_text_end
);

    logic job_push;
    t_job job_in;
    logic queue_full;
    logic job_pop;
    logic job_empty;
    t_job job_head;

    assign full = queue_full;

    u2u_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_text_byte  (i_text_byte),
        .i_text_last  (i_text_last),
        .i_queue_full (queue_full),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (queue_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_head)
    );

    u2u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_code_unit (o_code_unit),
        .o_run_last  (o_run_last),
        .o_text_end  (o_text_end)
    );

endmodule
